### src/mi3_pkg.sv
// mi3_pkg: widths, types and pipeline constants for the 3x3 matrix inverse.
// Used by every module in src; no dependencies.
package mi3_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int NUM_ELEM   = 9;

  // product, cofactor, determinant term and determinant widths
  localparam int PW = 2 * DATA_WIDTH;
  localparam int CW = PW + 1;
  localparam int HW = 2 * DATA_WIDTH + 1;
  localparam int TW = 3 * DATA_WIDTH + 1;
  localparam int DW = 3 * DATA_WIDTH + 3;
  // shifted dividend and divider remainder widths
  localparam int NW = CW + 2 * FRAC_BITS;
  localparam int RW = ((NW > DW + DATA_WIDTH - 1) ? NW : DW + DATA_WIDTH - 1) + 1;

  localparam int PIPE_LAT = DATA_WIDTH + 7;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [CW-1:0]         cof_t;
  typedef logic signed [DW-1:0]         det_t;

  typedef struct packed {
    logic  singular;
    data_t value;
  } lane_out_t;

endpackage

### src/mi3_cofactor.sv
// mi3_cofactor: two-stage array forming the nine adjugate cofactors.
// Depends on mi3_pkg.
module mi3_cofactor import mi3_pkg::*; (
  input  logic  clk_i,
  input  data_t m_i   [NUM_ELEM],
  output cof_t  cof_o [NUM_ELEM],
  output data_t col_o [3]
);

  // cofactor k = m[p]*m[q] - m[s]*m[t]
  localparam int unsigned CofIdx [NUM_ELEM][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  logic signed [PW-1:0] pa_q [NUM_ELEM];
  logic signed [PW-1:0] pb_q [NUM_ELEM];
  cof_t                 cof_q [NUM_ELEM];
  data_t                col1_q [3];
  data_t                col2_q [3];

  for (genvar k = 0; k < NUM_ELEM; k++) begin : g_cof
    always_ff @(posedge clk_i) begin
      pa_q[k]  <= m_i[CofIdx[k][0]] * m_i[CofIdx[k][1]];
      pb_q[k]  <= m_i[CofIdx[k][2]] * m_i[CofIdx[k][3]];
      cof_q[k] <= {pa_q[k][PW-1], pa_q[k]} - {pb_q[k][PW-1], pb_q[k]};
    end
    assign cof_o[k] = cof_q[k];
  end

  for (genvar j = 0; j < 3; j++) begin : g_col
    always_ff @(posedge clk_i) begin
      col1_q[j] <= m_i[3*j];
      col2_q[j] <= col1_q[j];
    end
    assign col_o[j] = col2_q[j];
  end

endmodule

### src/mi3_det.sv
// mi3_det: three-stage determinant from column 0 and its cofactors;
// carries the cofactors alongside. Depends on mi3_pkg.
module mi3_det import mi3_pkg::*; (
  input  logic  clk_i,
  input  cof_t  cof_i [NUM_ELEM],
  input  data_t col_i [3],
  output det_t  det_o,
  output cof_t  cof_o [NUM_ELEM]
);

  logic signed [HW-1:0] ph_q [3];
  logic signed [HW-1:0] pl_q [3];
  logic signed [TW-1:0] term_q [3];
  det_t                 det_q;
  cof_t                 c1_q [NUM_ELEM];
  cof_t                 c2_q [NUM_ELEM];
  cof_t                 c3_q [NUM_ELEM];

  // 32x65 product split into a signed high half and an unsigned low half
  for (genvar j = 0; j < 3; j++) begin : g_term
    always_ff @(posedge clk_i) begin
      ph_q[j]   <= col_i[j] * $signed(cof_i[j][CW-1:DATA_WIDTH]);
      pl_q[j]   <= col_i[j] * $signed({1'b0, cof_i[j][DATA_WIDTH-1:0]});
      term_q[j] <= {ph_q[j][TW-DATA_WIDTH-1:0], {DATA_WIDTH{1'b0}}}
                 + {{(TW-HW){pl_q[j][HW-1]}}, pl_q[j]};
    end
  end

  always_ff @(posedge clk_i) begin
    det_q <= {{(DW-TW){term_q[0][TW-1]}}, term_q[0]}
           + {{(DW-TW){term_q[1][TW-1]}}, term_q[1]}
           + {{(DW-TW){term_q[2][TW-1]}}, term_q[2]};
  end

  for (genvar k = 0; k < NUM_ELEM; k++) begin : g_pass
    always_ff @(posedge clk_i) begin
      c1_q[k] <= cof_i[k];
      c2_q[k] <= c1_q[k];
      c3_q[k] <= c2_q[k];
    end
    assign cof_o[k] = c3_q[k];
  end

  assign det_o = det_q;

endmodule

### src/mi3_div_lane.sv
// mi3_div_lane: one result lane; pipelined restoring divide of a cofactor
// by the determinant, one quotient bit per stage, with saturation.
// Depends on mi3_pkg.
module mi3_div_lane import mi3_pkg::*; (
  input  logic      clk_i,
  input  cof_t      cof_i,
  input  det_t      det_i,
  output lane_out_t lane_o
);

  localparam int W = DATA_WIDTH;

  logic [NW-1:0] n_q;
  logic [DW-1:0] da_q;
  logic          neg_q;
  logic          zero_q;
  logic [CW-1:0] cabs;
  logic [DW-1:0] dabs;

  logic [RW-1:0] r_q    [W];
  logic [DW-1:0] d_q    [W];
  logic [W-1:0]  q_q    [W];
  logic          ovf_q  [W];
  logic          sneg_q [W];
  logic          szero_q[W];

  assign cabs = cof_i[CW-1] ? CW'(-cof_i) : CW'(cof_i);
  assign dabs = det_i[DW-1] ? DW'(-det_i) : DW'(det_i);

  always_ff @(posedge clk_i) begin
    n_q    <= {cabs, {(2*FRAC_BITS){1'b0}}};
    da_q   <= dabs;
    neg_q  <= cof_i[CW-1] ^ det_i[DW-1];
    zero_q <= (det_i == '0);
  end

  // first stage: quotient at or above 2^(W-1) saturates
  always_ff @(posedge clk_i) begin
    ovf_q[0]   <= {{(RW-NW){1'b0}}, n_q} >= ({{(RW-DW){1'b0}}, da_q} << (W-1));
    r_q[0]     <= {{(RW-NW){1'b0}}, n_q};
    d_q[0]     <= da_q;
    q_q[0]     <= '0;
    sneg_q[0]  <= neg_q;
    szero_q[0] <= zero_q;
  end

  for (genvar s = 1; s < W; s++) begin : g_step
    logic [RW-1:0] ds;
    logic          take;
    assign ds   = {{(RW-DW){1'b0}}, d_q[s-1]} << (W-1-s);
    assign take = !ovf_q[s-1] && (r_q[s-1] >= ds);
    always_ff @(posedge clk_i) begin
      r_q[s]         <= take ? r_q[s-1] - ds : r_q[s-1];
      // lower bits are still clear here, so OR in this stage's bit
      q_q[s]         <= q_q[s-1] | ({{(W-1){1'b0}}, take} << (W-1-s));
      d_q[s]         <= d_q[s-1];
      ovf_q[s]       <= ovf_q[s-1];
      sneg_q[s]      <= sneg_q[s-1];
      szero_q[s]     <= szero_q[s-1];
    end
  end

  always_comb begin
    lane_o.singular = szero_q[W-1];
    if (szero_q[W-1]) begin
      lane_o.value = '0;
    end else if (ovf_q[W-1]) begin
      lane_o.value = sneg_q[W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      lane_o.value = sneg_q[W-1] ? -q_q[W-1] : q_q[W-1];
    end
  end

endmodule

### src/matrix3x3_inverse.sv
// matrix3x3_inverse: top level; cofactor array, determinant, nine divide
// lanes and the output merge. Depends on mi3_pkg, mi3_cofactor, mi3_det, mi3_div_lane.
//
//  channel  | ports                      | transfer
//  ---------+----------------------------+---------------------------------
//  command  | start_i, busy_o, m00..m22  | edge with start_i high, busy_o low
//  result   | valid_o, r00..r22, singular| edge ending the valid_o cycle
//
// One matrix per cycle; busy_o never rises. Each result passes 2 cofactor stages,
// 3 determinant stages, the divider input register, its saturation check stage,
// one quotient bit per further divider stage, and the output register.
// Reset clears only the result strobe pipeline; the datapath registers are not reset.
// The receiver cannot stall; results are never held.
module matrix3x3_inverse import mi3_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  output logic  busy_o,
  input  data_t m00_i, input data_t m01_i, input data_t m02_i,
  input  data_t m10_i, input data_t m11_i, input data_t m12_i,
  input  data_t m20_i, input data_t m21_i, input data_t m22_i,
  output logic  valid_o,
  output data_t r00_o, output data_t r01_o, output data_t r02_o,
  output data_t r10_o, output data_t r11_o, output data_t r12_o,
  output data_t r20_o, output data_t r21_o, output data_t r22_o,
  output logic  singular_o
);

  data_t               m [NUM_ELEM];
  cof_t                cof_a [NUM_ELEM];
  cof_t                cof_b [NUM_ELEM];
  data_t               col [3];
  det_t                det;
  lane_out_t           lane [NUM_ELEM];
  data_t               res_q [NUM_ELEM];
  logic                sing_q;
  logic [PIPE_LAT-1:0] valid_q, valid_d;

  assign m = '{m00_i, m01_i, m02_i, m10_i, m11_i, m12_i, m20_i, m21_i, m22_i};

  mi3_cofactor u_cof (.clk_i(clk_i), .m_i(m), .cof_o(cof_a), .col_o(col));

  mi3_det u_det (.clk_i(clk_i), .cof_i(cof_a), .col_i(col), .det_o(det), .cof_o(cof_b));

  for (genvar k = 0; k < NUM_ELEM; k++) begin : g_lane
    mi3_div_lane u_lane (.clk_i(clk_i), .cof_i(cof_b[k]), .det_i(det), .lane_o(lane[k]));
    always_ff @(posedge clk_i) begin
      res_q[k] <= lane[k].value;
    end
  end

  always_ff @(posedge clk_i) begin
    sing_q <= lane[0].singular;
  end

  assign busy_o  = 1'b0;
  assign valid_d = {valid_q[PIPE_LAT-2:0], start_i & ~busy_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign valid_o    = valid_q[PIPE_LAT-1];
  assign singular_o = sing_q;
  assign r00_o = res_q[0];
  assign r01_o = res_q[1];
  assign r02_o = res_q[2];
  assign r10_o = res_q[3];
  assign r11_o = res_q[4];
  assign r12_o = res_q[5];
  assign r20_o = res_q[6];
  assign r21_o = res_q[7];
  assign r22_o = res_q[8];

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##PIPE_LAT valid_o)
    else $error("result strobe missing after transfer");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && singular_o |-> (r00_o == '0) && (r11_o == '0) && (r22_o == '0)
                           && (r01_o == '0) && (r12_o == '0) && (r20_o == '0))
    else $error("singular result not zero");

  // lane outputs hold a real transfer in the cycle before the strobe
  a_lane_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[PIPE_LAT-2] |-> lane[0].singular == lane[8].singular)
    else $error("lanes disagree on singular determinant");

endmodule
